@@ hw/rtl/pkal_pkg.sv @@
// Package for the per-key alert pass limiter: sizes, codes, types.
// Used by pkal_if, the limiter and the bench; depends on nothing.
package pkal_pkg;
	localparam int KEY_ENTRIES = 64;
	localparam int ALERT_TYPES = 64;
	localparam int KEY_IW = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
	localparam int KCNT_W = $clog2(KEY_ENTRIES + 1);
	localparam int TYPE_IW = (ALERT_TYPES > 1) ? $clog2(ALERT_TYPES) : 1;
	localparam int IDX_W = (KEY_IW > TYPE_IW) ? KEY_IW : TYPE_IW;
	localparam int KEY_AW = 1 + KEY_IW;
	localparam int CNT_AW = 2 + IDX_W;
	localparam int KEY_W = 40;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 64;
	localparam logic [31:0] LIMIT_RESET = 32'd100;
	localparam logic [6:0] MAXKEYS_RESET = 7'd64;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		FUNC_CRIT = 2'd0,
		FUNC_UNK = 2'd1,
		FUNC_TYPE = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_COUNTED = 2'd0,
		ST_NO_ROOM = 2'd1,
		ST_UNIMPL = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEFAULT_LIMIT = 4'd0,
		REG_CRIT_LIMIT = 4'd1,
		REG_UNK_LIMIT = 4'd2,
		REG_UNK_MAX_KEYS = 4'd3,
		REG_KEY_OVR_MATCH = 4'd4,
		REG_KEY_OVR_LIMIT = 4'd5,
		REG_TYPE_OVR_MASK = 4'd6,
		REG_TYPE_OVR_LIMIT = 4'd7
	} reg_idx_t;

	// counter memory regions
	typedef enum logic [1:0] {
		RGN_CRIT = 2'd0,
		RGN_UNK = 2'd1,
		RGN_TYPE = 2'd2
	} rgn_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CRD,
		S_UPD,
		S_DONE
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
	endfunction
endpackage

@@ hw/rtl/pkal_if.sv @@
// Channel interfaces: alert beats in, result beats out, config writes.
// Depends on pkal_pkg.
interface pkal_alert_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [15:0] instance_id;
	logic [7:0] sensor_id;
	logic [15:0] event_id;
	logic [5:0] alert_type;
	logic alert_known;
	modport source(output valid, func, instance_id, sensor_id, event_id, alert_type,
		alert_known, input ready);
	modport sink(input valid, func, instance_id, sensor_id, event_id, alert_type,
		alert_known, output ready);
endinterface

interface pkal_result_if;
	logic valid;
	logic ready;
	logic passed;
	logic [1:0] status;
	logic [31:0] entry_passed_count;
	logic [31:0] entry_filtered_count;
	logic [31:0] overflow_drop_count;
	modport source(output valid, passed, status, entry_passed_count, entry_filtered_count,
		overflow_drop_count, input ready);
	modport sink(input valid, passed, status, entry_passed_count, entry_filtered_count,
		overflow_drop_count, output ready);
endinterface

interface pkal_cfg_if;
	logic valid;
	logic ready;
	logic [pkal_pkg::CFG_IDX_W-1:0] index;
	logic [pkal_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/per_key_alert_pass_limiter.sv @@
// Per-key alert pass limiter: one alert in, one pass/drop result out.
// Path, accept to result valid: clear/unimplemented go through S_DONE; type alerts through
// S_CRD and S_UPD; keyed alerts first run S_SEARCH over the keys held in that table (up to 64).
// One alert at a time.
// arst_n clears tables (fill counts, type valid bits) and config to reset values.
// Uses pkal_pkg, pkal_if and pkal_ram.
module per_key_alert_pass_limiter (
	input logic clk,
	input logic arst_n,
	pkal_alert_if.sink alert,
	pkal_result_if.source result,
	pkal_cfg_if.sink cfg
);
	// config registers
	logic [31:0] default_limit_q, crit_limit_q, unk_limit_q, ovr_limit_q, type_limit_q;
	logic [6:0] max_keys_q;
	logic [40:0] ovr_match_q;
	logic [63:0] type_mask_q;

	// table state
	logic [pkal_pkg::KCNT_W-1:0] crit_cnt_q, unk_cnt_q;
	logic [31:0] ovf_q;
	logic [pkal_pkg::ALERT_TYPES-1:0] tvalid_q;

	// captured alert
	pkal_pkg::func_t func_q;
	logic [pkal_pkg::KEY_W-1:0] key_q;
	logic [5:0] type_q;

	pkal_pkg::state_t state_q, state_d;
	logic [pkal_pkg::KCNT_W-1:0] ptr_q;
	logic pend_s1;
	logic [pkal_pkg::KEY_IW-1:0] pidx_s1;
	logic [pkal_pkg::KEY_IW-1:0] idx_q;
	logic new_q;
	pkal_pkg::status_t dstat_q;

	// result register
	logic out_valid_q, out_passed_q;
	logic [1:0] out_status_q;
	logic [31:0] out_pc_q, out_fc_q, out_ovf_q;

	// memory ports
	logic key_we, key_re, cnt_we, cnt_re;
	logic [pkal_pkg::KEY_AW-1:0] key_waddr, key_raddr;
	logic [pkal_pkg::KEY_W-1:0] key_rdata;
	logic [pkal_pkg::CNT_AW-1:0] cnt_addr;
	logic [63:0] cnt_wdata, cnt_rdata;

	logic in_acc, unk_tbl, type_ok, hit, table_full;
	logic [pkal_pkg::KCNT_W-1:0] tbl_cnt;
	logic [31:0] cap, limit, cur_p, cur_f, new_p, new_f;
	logic pass;
	logic [pkal_pkg::IDX_W-1:0] cnt_idx;
	pkal_pkg::rgn_t rgn;

	assign alert.ready = (state_q == pkal_pkg::S_IDLE);
	assign in_acc = alert.valid && alert.ready;
	assign cfg.ready = 1'b1;

	assign unk_tbl = (func_q == pkal_pkg::FUNC_UNK);
	assign tbl_cnt = unk_tbl ? unk_cnt_q : crit_cnt_q;
	assign cap = (32'(max_keys_q) > pkal_pkg::KEY_ENTRIES) ? pkal_pkg::KEY_ENTRIES
		: 32'(max_keys_q);
	assign table_full = unk_tbl ? (32'(unk_cnt_q) >= cap)
		: (32'(crit_cnt_q) >= pkal_pkg::KEY_ENTRIES);
	assign hit = pend_s1 && (key_rdata == key_q);
	assign type_ok = alert.alert_known && (32'(alert.alert_type) < pkal_pkg::ALERT_TYPES);

	// limit and counter update, valid in S_UPD
	always_comb begin
		case (func_q)
			pkal_pkg::FUNC_CRIT: limit = (ovr_match_q[40] && ovr_match_q[39:0] == key_q)
				? ovr_limit_q : crit_limit_q;
			pkal_pkg::FUNC_UNK: limit = unk_limit_q;
			default: limit = type_mask_q[type_q] ? type_limit_q : default_limit_q;
		endcase
	end

	always_comb begin
		if (new_q || (func_q == pkal_pkg::FUNC_TYPE
				&& !tvalid_q[pkal_pkg::TYPE_IW'(type_q)])) begin
			cur_p = '0;
			cur_f = '0;
		end else begin
			cur_p = cnt_rdata[63:32];
			cur_f = cnt_rdata[31:0];
		end
		pass = limit > cur_p;
		new_p = pass ? pkal_pkg::sat_inc(cur_p) : cur_p;
		new_f = pass ? cur_f : pkal_pkg::sat_inc(cur_f);
	end

	always_comb begin
		case (func_q)
			pkal_pkg::FUNC_CRIT: rgn = pkal_pkg::RGN_CRIT;
			pkal_pkg::FUNC_UNK: rgn = pkal_pkg::RGN_UNK;
			default: rgn = pkal_pkg::RGN_TYPE;
		endcase
		cnt_idx = (func_q == pkal_pkg::FUNC_TYPE) ? pkal_pkg::IDX_W'(type_q)
			: pkal_pkg::IDX_W'(idx_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pkal_pkg::S_IDLE: begin
				if (in_acc) begin
					case (alert.func)
						pkal_pkg::FUNC_CRIT, pkal_pkg::FUNC_UNK: state_d = pkal_pkg::S_SEARCH;
						pkal_pkg::FUNC_TYPE: state_d = type_ok ? pkal_pkg::S_CRD
							: pkal_pkg::S_DONE;
						default: state_d = pkal_pkg::S_DONE;
					endcase
				end
			end
			pkal_pkg::S_SEARCH: begin
				if (hit) begin
					state_d = pkal_pkg::S_CRD;
				end else if (!pend_s1 && ptr_q >= tbl_cnt) begin
					state_d = table_full ? pkal_pkg::S_DONE : pkal_pkg::S_CRD;
				end
			end
			pkal_pkg::S_CRD: state_d = pkal_pkg::S_UPD;
			pkal_pkg::S_UPD: if (!out_valid_q) state_d = pkal_pkg::S_IDLE;
			pkal_pkg::S_DONE: if (!out_valid_q) state_d = pkal_pkg::S_IDLE;
			default: state_d = pkal_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		key_re = 1'b0;
		key_we = 1'b0;
		cnt_re = 1'b0;
		cnt_we = 1'b0;
		key_raddr = {unk_tbl, ptr_q[pkal_pkg::KEY_IW-1:0]};
		key_waddr = {unk_tbl, idx_q};
		cnt_addr = {rgn, cnt_idx};
		cnt_wdata = {new_p, new_f};
		case (state_q)
			pkal_pkg::S_SEARCH: key_re = (ptr_q < tbl_cnt) && !hit;
			pkal_pkg::S_CRD: cnt_re = 1'b1;
			pkal_pkg::S_UPD: begin
				cnt_we = !out_valid_q;
				key_we = !out_valid_q && new_q;
			end
			default: ;
		endcase
	end

	pkal_ram #(.WIDTH(pkal_pkg::KEY_W), .DEPTH(2 ** pkal_pkg::KEY_AW)) u_key_mem (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_q),
		.re(key_re), .raddr(key_raddr), .rdata(key_rdata)
	);

	pkal_ram #(.WIDTH(64), .DEPTH(2 ** pkal_pkg::CNT_AW)) u_cnt_mem (
		.clk(clk), .we(cnt_we), .waddr(cnt_addr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_addr), .rdata(cnt_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_limit_q <= pkal_pkg::LIMIT_RESET;
			crit_limit_q <= pkal_pkg::LIMIT_RESET;
			unk_limit_q <= pkal_pkg::LIMIT_RESET;
			max_keys_q <= pkal_pkg::MAXKEYS_RESET;
			ovr_match_q <= '0;
			ovr_limit_q <= pkal_pkg::LIMIT_RESET;
			type_mask_q <= '0;
			type_limit_q <= pkal_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				pkal_pkg::REG_DEFAULT_LIMIT: default_limit_q <= cfg.data[31:0];
				pkal_pkg::REG_CRIT_LIMIT: crit_limit_q <= cfg.data[31:0];
				pkal_pkg::REG_UNK_LIMIT: unk_limit_q <= cfg.data[31:0];
				pkal_pkg::REG_UNK_MAX_KEYS: max_keys_q <= cfg.data[6:0];
				pkal_pkg::REG_KEY_OVR_MATCH: ovr_match_q <= cfg.data[40:0];
				pkal_pkg::REG_KEY_OVR_LIMIT: ovr_limit_q <= cfg.data[31:0];
				pkal_pkg::REG_TYPE_OVR_MASK: type_mask_q <= cfg.data;
				pkal_pkg::REG_TYPE_OVR_LIMIT: type_limit_q <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	// captured beat; payload only
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= pkal_pkg::func_t'(alert.func);
			key_q <= {alert.instance_id, alert.sensor_id, alert.event_id};
			type_q <= alert.alert_type;
		end
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pkal_pkg::S_IDLE;
			ptr_q <= '0;
			pend_s1 <= 1'b0;
			pidx_s1 <= '0;
			idx_q <= '0;
			new_q <= 1'b0;
			dstat_q <= pkal_pkg::ST_CLEARED;
			crit_cnt_q <= '0;
			unk_cnt_q <= '0;
			ovf_q <= '0;
			tvalid_q <= '0;
			out_valid_q <= 1'b0;
			out_passed_q <= 1'b0;
			out_status_q <= '0;
			out_pc_q <= '0;
			out_fc_q <= '0;
			out_ovf_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pkal_pkg::S_IDLE: begin
					ptr_q <= '0;
					pend_s1 <= 1'b0;
					new_q <= 1'b0;
					dstat_q <= (alert.func == pkal_pkg::FUNC_CLEAR) ? pkal_pkg::ST_CLEARED
						: pkal_pkg::ST_UNIMPL;
				end
				pkal_pkg::S_SEARCH: begin
					pend_s1 <= key_re;
					pidx_s1 <= ptr_q[pkal_pkg::KEY_IW-1:0];
					if (key_re) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit) begin
						idx_q <= pidx_s1;
					end else if (!pend_s1 && ptr_q >= tbl_cnt) begin
						idx_q <= tbl_cnt[pkal_pkg::KEY_IW-1:0];
						new_q <= !table_full;
						dstat_q <= pkal_pkg::ST_NO_ROOM;
					end
				end
				pkal_pkg::S_UPD: begin
					if (!out_valid_q) begin
						if (new_q && unk_tbl) unk_cnt_q <= unk_cnt_q + 1'b1;
						if (new_q && func_q == pkal_pkg::FUNC_CRIT) crit_cnt_q <= crit_cnt_q + 1'b1;
						if (func_q == pkal_pkg::FUNC_TYPE) begin
							tvalid_q[pkal_pkg::TYPE_IW'(type_q)] <= 1'b1;
						end
						out_valid_q <= 1'b1;
						out_passed_q <= pass;
						out_status_q <= pkal_pkg::ST_COUNTED;
						out_pc_q <= new_p;
						out_fc_q <= new_f;
						out_ovf_q <= ovf_q;
					end
				end
				pkal_pkg::S_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_passed_q <= 1'b0;
						out_status_q <= dstat_q;
						out_pc_q <= '0;
						out_fc_q <= '0;
						if (dstat_q == pkal_pkg::ST_CLEARED) begin
							crit_cnt_q <= '0;
							unk_cnt_q <= '0;
							ovf_q <= '0;
							tvalid_q <= '0;
							out_ovf_q <= '0;
						end else if (dstat_q == pkal_pkg::ST_NO_ROOM && unk_tbl) begin
							ovf_q <= pkal_pkg::sat_inc(ovf_q);
							out_ovf_q <= pkal_pkg::sat_inc(ovf_q);
						end else begin
							out_ovf_q <= ovf_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.passed = out_passed_q;
	assign result.status = out_status_q;
	assign result.entry_passed_count = out_pc_q;
	assign result.entry_filtered_count = out_fc_q;
	assign result.overflow_drop_count = out_ovf_q;

`ifndef SYNTHESIS
	a_crit_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(crit_cnt_q) <= pkal_pkg::KEY_ENTRIES) else $error("crit fill count too large");
	a_unk_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		unk_cnt_q != $past(unk_cnt_q) |-> unk_cnt_q == $past(unk_cnt_q) + 1'b1
		|| unk_cnt_q == '0) else $error("unk fill count jumped");
	a_no_mem_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(key_we && key_re)) else $error("key memory read and write together");
	a_search_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pkal_pkg::S_SEARCH |-> ptr_q <= tbl_cnt) else $error("search overran");
`endif
endmodule

@@ hw/rtl/pkal_ram.sv @@
// Generic single-port-write, single-port-read RAM, registered read data.
// No dependencies.
module pkal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for per_key_alert_pass_limiter: random and directed alert beats,
// predicted verdicts checked beat by beat. Needs pkal_pkg, pkal_if and the block's RTL.
module tb;
	localparam int HALF = 6;
	localparam int CYCLE_LIMIT = 400000;
	// drain time for an alert still in flight: worst keyed search plus margin
	localparam int SETTLE = 100;
	localparam int LONG_HOLD = 400;
	// an index past the register map; the block must ignore it
	localparam logic [pkal_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

	typedef struct packed {
		pkal_pkg::func_t func;
		logic [15:0] instance_id;
		logic [7:0] sensor_id;
		logic [15:0] event_id;
		logic [5:0] alert_type;
		logic alert_known;
	} alert_beat_t;

	typedef struct packed {
		logic passed;
		pkal_pkg::status_t status;
		logic [31:0] entry_passed_count;
		logic [31:0] entry_filtered_count;
		logic [31:0] overflow_drop_count;
	} verdict_t;

	logic clk;
	logic arst_n;

	pkal_alert_if alert_ch();
	pkal_result_if result_ch();
	pkal_cfg_if cfg_ch();

	per_key_alert_pass_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.alert(alert_ch.sink),
		.result(result_ch.source),
		.cfg(cfg_ch.sink)
	);

	// ---------------------------------------------------------------
	// Limiter shadow: configuration, key tables and counters
	// ---------------------------------------------------------------
	logic [31:0] lim_default = pkal_pkg::LIMIT_RESET;
	logic [31:0] lim_crit = pkal_pkg::LIMIT_RESET;
	logic [31:0] lim_unk = pkal_pkg::LIMIT_RESET;
	logic [6:0] unk_max_keys = pkal_pkg::MAXKEYS_RESET;
	logic [40:0] key_ovr_match = '0;
	logic [31:0] key_ovr_limit = pkal_pkg::LIMIT_RESET;
	logic [63:0] type_ovr_mask = '0;
	logic [31:0] type_ovr_limit = pkal_pkg::LIMIT_RESET;

	logic [40:0] crit_tbl[pkal_pkg::KEY_ENTRIES];
	logic [31:0] crit_pass[pkal_pkg::KEY_ENTRIES];
	logic [31:0] crit_filt[pkal_pkg::KEY_ENTRIES];
	int crit_fill;
	logic [40:0] unk_tbl[pkal_pkg::KEY_ENTRIES];
	logic [31:0] unk_pass[pkal_pkg::KEY_ENTRIES];
	logic [31:0] unk_filt[pkal_pkg::KEY_ENTRIES];
	int unk_fill;
	logic [31:0] type_pass[pkal_pkg::ALERT_TYPES];
	logic [31:0] type_filt[pkal_pkg::ALERT_TYPES];
	logic [31:0] unk_drops;

	function automatic void wipe_tables();
		for (int i = 0; i < pkal_pkg::KEY_ENTRIES; i++) begin
			crit_tbl[i] = '0; crit_pass[i] = '0; crit_filt[i] = '0;
			unk_tbl[i] = '0; unk_pass[i] = '0; unk_filt[i] = '0;
		end
		for (int i = 0; i < pkal_pkg::ALERT_TYPES; i++) begin
			type_pass[i] = '0; type_filt[i] = '0;
		end
		crit_fill = 0;
		unk_fill = 0;
		unk_drops = '0;
	endfunction

	function automatic int key_slot(input logic [40:0] tbl[pkal_pkg::KEY_ENTRIES],
			input logic [39:0] key);
		for (int i = 0; i < pkal_pkg::KEY_ENTRIES; i++)
			if (tbl[i][40] && tbl[i][39:0] == key)
				return i;
		return -1;
	endfunction

	function automatic logic sat_bump(input logic [31:0] v, output logic [31:0] nv);
		nv = (v == pkal_pkg::CNT_MAX) ? v : v + 32'd1;
		return 1'b1;
	endfunction

	// pass while the passed count is under the limit, else count as filtered
	function automatic logic gate(input logic [31:0] limit, inout logic [31:0] p,
			inout logic [31:0] f);
		logic [31:0] nv;
		logic dummy;
		if (limit > p) begin
			dummy = sat_bump(p, nv);
			p = nv;
			return 1'b1;
		end
		dummy = sat_bump(f, nv);
		f = nv;
		return 1'b0;
	endfunction

	function automatic verdict_t pass_verdict(input alert_beat_t a);
		verdict_t v;
		logic [39:0] key;
		logic [31:0] limit;
		logic [31:0] p;
		logic [31:0] f;
		logic [31:0] nv;
		logic dummy;
		int idx;
		int cap;
		v.passed = 1'b0;
		v.status = pkal_pkg::ST_COUNTED;
		v.entry_passed_count = '0;
		v.entry_filtered_count = '0;
		key = {a.instance_id, a.sensor_id, a.event_id};
		case (a.func)
			pkal_pkg::FUNC_CLEAR: begin
				wipe_tables();
				v.status = pkal_pkg::ST_CLEARED;
			end
			pkal_pkg::FUNC_CRIT: begin
				idx = key_slot(crit_tbl, key);
				if (idx < 0 && crit_fill < pkal_pkg::KEY_ENTRIES) begin
					idx = crit_fill;
					crit_tbl[idx] = {1'b1, key};
					crit_pass[idx] = '0;
					crit_filt[idx] = '0;
					crit_fill++;
				end
				if (idx < 0) begin
					v.status = pkal_pkg::ST_NO_ROOM;
				end else begin
					limit = (key_ovr_match[40] && key_ovr_match[39:0] == key) ?
						key_ovr_limit : lim_crit;
					p = crit_pass[idx];
					f = crit_filt[idx];
					v.passed = gate(limit, p, f);
					crit_pass[idx] = p;
					crit_filt[idx] = f;
					v.entry_passed_count = p;
					v.entry_filtered_count = f;
				end
			end
			pkal_pkg::FUNC_UNK: begin
				cap = (unk_max_keys > pkal_pkg::KEY_ENTRIES) ? pkal_pkg::KEY_ENTRIES
					: int'(unk_max_keys);
				idx = key_slot(unk_tbl, key);
				if (idx < 0 && unk_fill < cap) begin
					idx = unk_fill;
					unk_tbl[idx] = {1'b1, key};
					unk_pass[idx] = '0;
					unk_filt[idx] = '0;
					unk_fill++;
				end
				if (idx < 0) begin
					v.status = pkal_pkg::ST_NO_ROOM;
					dummy = sat_bump(unk_drops, nv);
					unk_drops = nv;
				end else begin
					p = unk_pass[idx];
					f = unk_filt[idx];
					v.passed = gate(lim_unk, p, f);
					unk_pass[idx] = p;
					unk_filt[idx] = f;
					v.entry_passed_count = p;
					v.entry_filtered_count = f;
				end
			end
			default: begin
				if (!a.alert_known || int'(a.alert_type) >= pkal_pkg::ALERT_TYPES) begin
					v.status = pkal_pkg::ST_UNIMPL;
				end else begin
					limit = type_ovr_mask[a.alert_type] ? type_ovr_limit : lim_default;
					p = type_pass[a.alert_type];
					f = type_filt[a.alert_type];
					v.passed = gate(limit, p, f);
					type_pass[a.alert_type] = p;
					type_filt[a.alert_type] = f;
					v.entry_passed_count = p;
					v.entry_filtered_count = f;
				end
			end
		endcase
		v.overflow_drop_count = unk_drops;
		return v;
	endfunction

	function automatic void apply_reg(input logic [pkal_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] d);
		case (idx)
			pkal_pkg::REG_DEFAULT_LIMIT: lim_default = d[31:0];
			pkal_pkg::REG_CRIT_LIMIT: lim_crit = d[31:0];
			pkal_pkg::REG_UNK_LIMIT: lim_unk = d[31:0];
			pkal_pkg::REG_UNK_MAX_KEYS: unk_max_keys = d[6:0];
			pkal_pkg::REG_KEY_OVR_MATCH: key_ovr_match = d[40:0];
			pkal_pkg::REG_KEY_OVR_LIMIT: key_ovr_limit = d[31:0];
			pkal_pkg::REG_TYPE_OVR_MASK: type_ovr_mask = d;
			pkal_pkg::REG_TYPE_OVR_LIMIT: type_ovr_limit = d[31:0];
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Clock, queues, flags
	// ---------------------------------------------------------------
	initial clk = 1'b0;
	always #HALF clk = ~clk;

	alert_beat_t pending_alerts[$];
	verdict_t due_verdicts[$];
	int mismatches = 0;
	int cycles = 0;
	logic quiet;       // no idling on either side once set
	logic hold_pulse;  // one-cycle request for the long result stall

	// ---------------------------------------------------------------
	// Alert driver: offers the queue head, random gaps between beats
	// ---------------------------------------------------------------
	int tx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_ch.valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (alert_ch.valid && alert_ch.ready) begin
				due_verdicts.push_back(pass_verdict(pending_alerts[0]));
				void'(pending_alerts.pop_front());
			end
			if (alert_ch.valid && !alert_ch.ready) begin
				// beat still on offer: keep it steady
			end else if (tx_gap != 0) begin
				tx_gap <= tx_gap - 1;
				alert_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				tx_gap <= $urandom_range(0, 18);
				alert_ch.valid <= 1'b0;
			end else if (pending_alerts.size() != 0) begin
				alert_ch.valid <= 1'b1;
				alert_ch.func <= pending_alerts[0].func;
				alert_ch.instance_id <= pending_alerts[0].instance_id;
				alert_ch.sensor_id <= pending_alerts[0].sensor_id;
				alert_ch.event_id <= pending_alerts[0].event_id;
				alert_ch.alert_type <= pending_alerts[0].alert_type;
				alert_ch.alert_known <= pending_alerts[0].alert_known;
			end else begin
				alert_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: random stalls, one long hold, beat-by-beat check
	// ---------------------------------------------------------------
	int rx_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: status %0d passed %0d",
							result_ch.status, result_ch.passed);
				end else begin
					if (result_ch.passed !== due_verdicts[0].passed ||
							result_ch.status !== due_verdicts[0].status ||
							result_ch.entry_passed_count !== due_verdicts[0].entry_passed_count ||
							result_ch.entry_filtered_count !==
							due_verdicts[0].entry_filtered_count ||
							result_ch.overflow_drop_count !==
							due_verdicts[0].overflow_drop_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp p%0d s%0d pc%0d fc%0d of%0d, got p%0d s%0d pc%0d fc%0d of%0d",
								due_verdicts[0].passed, due_verdicts[0].status,
								due_verdicts[0].entry_passed_count,
								due_verdicts[0].entry_filtered_count,
								due_verdicts[0].overflow_drop_count,
								result_ch.passed, result_ch.status,
								result_ch.entry_passed_count,
								result_ch.entry_filtered_count,
								result_ch.overflow_drop_count);
					end
					void'(due_verdicts.pop_front());
				end
			end
			if (hold_pulse) begin
				rx_stall <= LONG_HOLD;
				result_ch.ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rx_stall <= $urandom_range(0, 18);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	logic [39:0] key_pool[8];

	function automatic alert_beat_t mk_alert(input pkal_pkg::func_t fn, input logic [39:0] key,
			input logic [5:0] atype, input logic known);
		alert_beat_t a;
		a.func = fn;
		{a.instance_id, a.sensor_id, a.event_id} = key;
		a.alert_type = atype;
		a.alert_known = known;
		return a;
	endfunction

	// mostly pooled keys so counters run into their limits; fresh_pct new keys
	function automatic alert_beat_t rand_alert(input int fresh_pct);
		int r;
		pkal_pkg::func_t fn;
		logic [39:0] key;
		r = $urandom_range(0, 99);
		fn = (r < 36) ? pkal_pkg::FUNC_CRIT : (r < 70) ? pkal_pkg::FUNC_UNK
			: (r < 97) ? pkal_pkg::FUNC_TYPE : pkal_pkg::FUNC_CLEAR;
		if ($urandom_range(0, 99) < fresh_pct)
			key = {$urandom, 8'($urandom_range(0, 255))};
		else
			key = key_pool[$urandom_range(0, 7)];
		return mk_alert(fn, key, 6'($urandom_range(0, 63)), $urandom_range(0, 9) != 0);
	endfunction

	task automatic wait_drained();
		while (pending_alerts.size() != 0 || due_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// register writes only with the block idle
	task automatic write_reg(input logic [pkal_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] d);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, d);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_pulse = 1'b0;
		alert_ch.valid = 1'b0;
		alert_ch.func = pkal_pkg::FUNC_CRIT;
		alert_ch.instance_id = '0;
		alert_ch.sensor_id = '0;
		alert_ch.event_id = '0;
		alert_ch.alert_type = '0;
		alert_ch.alert_known = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = pkal_pkg::REG_DEFAULT_LIMIT;
		cfg_ch.data = '0;
		wipe_tables();
		for (int i = 0; i < 8; i++)
			key_pool[i] = {$urandom, 8'($urandom_range(0, 255))};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every func, unknown types, clear
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CRIT, '0, '0, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CRIT, '0, '0, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CRIT, '1, '1, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_UNK, '0, '0, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_UNK, '1, '1, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_UNK, '1, '0, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_TYPE, '0, 6'd0, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_TYPE, '1, 6'd63, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_TYPE, '0, 6'd63, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_TYPE, '0, 6'd5, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_TYPE, '1, 6'd63, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CLEAR, '1, '1, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CRIT, '1, '1, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_UNK, key_pool[0], '0, 1'b0));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_TYPE, '0, 6'd63, 1'b1));
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CLEAR, '0, '0, 1'b0));

		// tight limits: filtering, small unknown-ID table, key and type overrides
		write_reg(pkal_pkg::REG_DEFAULT_LIMIT, 64'd2);
		write_reg(pkal_pkg::REG_CRIT_LIMIT, 64'd3);
		write_reg(pkal_pkg::REG_UNK_LIMIT, 64'd1);
		write_reg(pkal_pkg::REG_UNK_MAX_KEYS, 64'd4);
		write_reg(pkal_pkg::REG_KEY_OVR_MATCH, {23'd0, 1'b1, key_pool[1]});
		write_reg(pkal_pkg::REG_KEY_OVR_LIMIT, 64'd0);
		write_reg(pkal_pkg::REG_TYPE_OVR_MASK, {$urandom, $urandom});
		write_reg(pkal_pkg::REG_TYPE_OVR_LIMIT, 64'd1);
		write_reg(REG_UNUSED, '1);
		@(posedge clk);
		hold_pulse <= 1'b1;   // result side stalls while beats keep coming
		@(posedge clk);
		hold_pulse <= 1'b0;
		for (int i = 0; i < 130; i++)
			pending_alerts.push_back(rand_alert(10));

		// zero limits, no unknown-ID room, all types overridden to the top limit;
		// then more distinct critical keys than the table holds
		write_reg(pkal_pkg::REG_DEFAULT_LIMIT, 64'd0);
		write_reg(pkal_pkg::REG_CRIT_LIMIT, 64'd0);
		write_reg(pkal_pkg::REG_UNK_LIMIT, 64'd0);
		write_reg(pkal_pkg::REG_UNK_MAX_KEYS, 64'd0);
		write_reg(pkal_pkg::REG_KEY_OVR_MATCH, {23'd0, 1'b1, 40'hFF_FFFF_FFFF});
		write_reg(pkal_pkg::REG_KEY_OVR_LIMIT, 64'hFFFF_FFFF);
		write_reg(pkal_pkg::REG_TYPE_OVR_MASK, '1);
		write_reg(pkal_pkg::REG_TYPE_OVR_LIMIT, 64'hFFFF_FFFF);
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CLEAR, '0, '0, 1'b0));
		for (int i = 0; i < 70; i++) begin
			pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CRIT,
				{i[15:0], 8'($urandom), 16'($urandom)}, '0, 1'b0));
			if (i % 7 == 0)
				pending_alerts.push_back(rand_alert(50));
		end
		pending_alerts.push_back(mk_alert(pkal_pkg::FUNC_CRIT, '1, '0, 1'b0));

		// top limits, unknown-ID capacity clipped to the table size
		write_reg(pkal_pkg::REG_DEFAULT_LIMIT, 64'hFFFF_FFFF);
		write_reg(pkal_pkg::REG_CRIT_LIMIT, 64'hFFFF_FFFF);
		write_reg(pkal_pkg::REG_UNK_LIMIT, 64'hFFFF_FFFF);
		write_reg(pkal_pkg::REG_UNK_MAX_KEYS, 64'd127);
		write_reg(pkal_pkg::REG_KEY_OVR_MATCH, {23'd0, 1'b0, key_pool[2]});
		write_reg(pkal_pkg::REG_TYPE_OVR_MASK, '0);
		for (int i = 0; i < 100; i++)
			pending_alerts.push_back(rand_alert(60));

		// moderate limits, and a closing stretch with no idling
		write_reg(pkal_pkg::REG_UNK_MAX_KEYS, 64'd64);
		write_reg(pkal_pkg::REG_UNK_LIMIT, 64'd5);
		write_reg(pkal_pkg::REG_CRIT_LIMIT, 64'd4);
		for (int i = 0; i < 40; i++)
			pending_alerts.push_back(rand_alert(30));
		wait_drained();
		quiet <= 1'b1;
		for (int i = 0; i < 40; i++)
			pending_alerts.push_back(rand_alert(30));

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && due_verdicts.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
